>>> src/indexed_line_blitter_macros.svh
// assertion macros for the indexed line blitter checker
// no dependencies; taken in by the checker file only
`ifndef INDEXED_LINE_BLITTER_MACROS_SVH
`define INDEXED_LINE_BLITTER_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define ILB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("indexed_line_blitter: assertion failed");

// next-cycle implication, also checked across reset
`define ILB_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("indexed_line_blitter: assertion failed");

`endif

>>> src/ilb_pkg.sv
// shared types, codes and defaults for the indexed line blitter
// no dependencies; imported by every module of the block
package ilb_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_HEADER  = 2'd1;
    localparam logic [1:0] OP_PIXEL   = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W          = 2;
    localparam logic [1:0] CFG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_OFFSET_X       = 2'd2;
    localparam logic [1:0] CFG_OFFSET_Y       = 2'd3;
    localparam int         CFG_DATA_W         = 11;

    // reset values of the configuration registers
    localparam logic [10:0] RST_DISPLAY_WIDTH  = 11'd320;
    localparam logic [10:0] RST_DISPLAY_HEIGHT = 11'd240;
    localparam logic [9:0]  RST_OFFSET_X       = 10'd112;
    localparam logic [9:0]  RST_OFFSET_Y       = 10'd72;

    // disposal code that restores the background
    localparam logic [2:0] DISPOSAL_RESTORE = 3'd2;

    // field widths
    localparam int COORD_W  = 10;
    localparam int EXTENT_W = 11;
    localparam int INDEX_W  = 8;
    localparam int COLOR_W  = 16;

    // parameter defaults
    localparam int DEF_BURST_MAX       = 256;
    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_COORD_BITS      = 10;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // command kinds in the queue
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic               run_start;
        logic               out_of_range;
    } t_cmd;

    // swap the two bytes of a colour word
    function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
        return {c[7:0], c[15:8]};
    endfunction

endpackage

>>> src/ilb_queue.sv
// small command queue that decouples the front and back parts
// depends on ilb_pkg for the command type and depth
module ilb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ilb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ilb_pkg::t_cmd o_data
);
    import ilb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/ilb_front.sv
// front part: config registers, line header clipping, pixel classification
// depends on ilb_pkg; pushes palette writes and visible pixels to the queue
module ilb_front #(
    parameter int BURST_MAX       = ilb_pkg::DEF_BURST_MAX,
    parameter int PALETTE_ENTRIES = ilb_pkg::DEF_PALETTE_ENTRIES,
    parameter int COORD_BITS      = ilb_pkg::DEF_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [ilb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ilb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_accept,
    input  logic [1:0]                      i_operation,
    input  logic [ilb_pkg::INDEX_W-1:0]     i_index,
    input  logic [ilb_pkg::COLOR_W-1:0]     i_palette_color,
    input  logic [ilb_pkg::COORD_W-1:0]     i_line_x,
    input  logic [ilb_pkg::COORD_W-1:0]     i_line_y,
    input  logic [ilb_pkg::EXTENT_W-1:0]    i_line_width,
    input  logic [ilb_pkg::INDEX_W-1:0]     i_transparent_index,
    input  logic [ilb_pkg::INDEX_W-1:0]     i_background_index,
    input  logic [2:0]                      i_disposal_mode,
    input  logic                            i_has_transparency,
    output logic                            o_push,
    output ilb_pkg::t_cmd                   o_cmd
);
    import ilb_pkg::*;

    localparam int BW    = (BURST_MAX > 1) ? $clog2(BURST_MAX) : 1;
    localparam int LIM_W = 13;
    localparam logic [LIM_W-1:0] EXTENT_LIM = LIM_W'(1 << COORD_BITS);

    // configuration
    logic [EXTENT_W-1:0] r_disp_w, r_disp_h;
    logic [COORD_W-1:0]  r_off_x, r_off_y;

    // line state
    logic [COORD_W-1:0]  r_origin_x;
    logic [COORD_W-1:0]  r_line_y;
    logic [EXTENT_W-1:0] r_vis_width;
    logic                r_dropped;
    logic [INDEX_W-1:0]  r_tkey, r_bkey;
    logic                r_restore, r_transp;
    logic [EXTENT_W-1:0] r_pos;
    logic [BW-1:0]       r_burst;

    // header arithmetic
    logic [LIM_W-1:0]    w_ext, h_ext;
    logic [EXTENT_W-1:0] clip_w, clip_h;
    logic [EXTENT_W-1:0] sx, sy, room, vis_w;
    logic                hdr_off_screen;
    logic                hdr_restore;

    // pixel classification
    logic                pix_active;
    logic [INDEX_W-1:0]  eff_index;
    logic                pix_skip;
    logic [BW:0]         burst_inc;
    logic [BW-1:0]       burst_next;
    logic                idx_in_range;

    // clip extents saturate at the coordinate range
    always_comb begin
        w_ext  = LIM_W'(r_disp_w);
        h_ext  = LIM_W'(r_disp_h);
        clip_w = (w_ext > EXTENT_LIM) ? EXTENT_W'(EXTENT_LIM) : r_disp_w;
        clip_h = (h_ext > EXTENT_LIM) ? EXTENT_W'(EXTENT_LIM) : r_disp_h;
    end

    // screen position and visible width of a new line
    always_comb begin
        sx             = EXTENT_W'(i_line_x) + EXTENT_W'(r_off_x);
        sy             = EXTENT_W'(i_line_y) + EXTENT_W'(r_off_y);
        hdr_off_screen = (sy >= clip_h) || (sx >= clip_w);
        room           = clip_w - sx;
        vis_w          = (i_line_width < room) ? i_line_width : room;
        hdr_restore    = (i_disposal_mode == DISPOSAL_RESTORE);
    end

    // per-pixel key handling and burst count
    always_comb begin
        pix_active   = !r_dropped && (r_pos < r_vis_width);
        eff_index    = (r_restore && i_index == r_tkey) ? r_bkey : i_index;
        pix_skip     = r_transp && (eff_index == r_tkey);
        burst_inc    = {1'b0, r_burst} + 1'b1;
        burst_next   = (burst_inc >= (BW+1)'(BURST_MAX)) ? '0 : burst_inc[BW-1:0];
        idx_in_range = ({1'b0, i_index} < (INDEX_W+1)'(PALETTE_ENTRIES));
    end

    // command toward the back part
    always_comb begin
        o_cmd.index        = (i_operation == OP_PIXEL) ? eff_index : i_index;
        o_cmd.color        = i_palette_color;
        o_cmd.screen_x     = r_origin_x + r_pos[COORD_W-1:0];
        o_cmd.screen_y     = r_line_y;
        o_cmd.run_start    = (r_burst == '0);
        o_cmd.out_of_range = ({1'b0, eff_index} >= (INDEX_W+1)'(PALETTE_ENTRIES));
        o_cmd.kind         = CMD_WRITE;
        o_push             = 1'b0;
        case (i_operation)
            OP_PALETTE: begin
                o_cmd.kind = CMD_WRITE;
                o_push     = i_accept && idx_in_range;
            end
            OP_PIXEL: begin
                o_cmd.kind = CMD_PIXEL;
                o_push     = i_accept && pix_active && !pix_skip;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= RST_DISPLAY_WIDTH;
            r_disp_h <= RST_DISPLAY_HEIGHT;
            r_off_x  <= RST_OFFSET_X;
            r_off_y  <= RST_OFFSET_Y;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DISPLAY_WIDTH:  r_disp_w <= i_cfg_data;
                CFG_DISPLAY_HEIGHT: r_disp_h <= i_cfg_data;
                CFG_OFFSET_X:       r_off_x  <= i_cfg_data[COORD_W-1:0];
                CFG_OFFSET_Y:       r_off_y  <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // line state update on header and pixel beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_line_y    <= '0;
            r_vis_width <= '0;
            r_dropped   <= 1'b1;
            r_tkey      <= '0;
            r_bkey      <= '0;
            r_restore   <= 1'b0;
            r_transp    <= 1'b0;
            r_pos       <= '0;
            r_burst     <= '0;
        end else if (i_accept) begin
            case (i_operation)
                OP_HEADER: begin
                    r_pos     <= '0;
                    r_burst   <= '0;
                    r_tkey    <= i_transparent_index;
                    r_bkey    <= i_background_index;
                    r_restore <= hdr_restore;
                    r_transp  <= i_has_transparency && !hdr_restore;
                    if (hdr_off_screen) begin
                        r_dropped   <= 1'b1;
                        r_vis_width <= '0;
                    end else begin
                        r_dropped   <= (vis_w == '0);
                        r_vis_width <= vis_w;
                        r_origin_x  <= sx[COORD_W-1:0];
                        r_line_y    <= sy[COORD_W-1:0];
                    end
                end
                OP_PIXEL: begin
                    if (pix_active) begin
                        r_pos   <= r_pos + 1'b1;
                        r_burst <= pix_skip ? '0 : burst_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/ilb_back.sv
// back part: palette memory, registered lookup and output register
// depends on ilb_pkg; drains one queue command per cycle unless the output stalls
module ilb_back #(
    parameter int PALETTE_ENTRIES = ilb_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  ilb_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ilb_pkg::COORD_W-1:0]   o_screen_x,
    output logic [ilb_pkg::COORD_W-1:0]   o_screen_y,
    output logic [ilb_pkg::COLOR_W-1:0]   o_pixel_word,
    output logic                          o_run_start
);
    import ilb_pkg::*;

    localparam int PA_W = $clog2(PALETTE_ENTRIES);

    logic [COLOR_W-1:0] r_palette [PALETTE_ENTRIES];
    logic [PA_W-1:0]    addr;

    // lookup stage
    logic               r_s1_valid;
    logic [COLOR_W-1:0] r_rd_data;
    logic [COORD_W-1:0] r_s1_x, r_s1_y;
    logic               r_s1_start, r_s1_zero;

    // output register
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [COLOR_W-1:0] r_out_word;
    logic               r_out_start;

    logic out_free, s1_free, take_pixel, take_write;

    // advance conditions
    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        s1_free    = !r_s1_valid || out_free;
        o_pop      = i_cmd_valid && s1_free;
        take_pixel = o_pop && (i_cmd.kind == CMD_PIXEL);
        take_write = o_pop && (i_cmd.kind == CMD_WRITE);
        addr       = i_cmd.index[PA_W-1:0];
    end

    // palette memory, one write or one read a cycle
    always_ff @(posedge i_clk) begin
        if (take_write) begin
            r_palette[addr] <= i_cmd.color;
        end
        if (take_pixel) begin
            r_rd_data <= r_palette[addr];
        end
    end

    // lookup stage payload
    always_ff @(posedge i_clk) begin
        if (take_pixel) begin
            r_s1_x     <= i_cmd.screen_x;
            r_s1_y     <= i_cmd.screen_y;
            r_s1_start <= i_cmd.run_start;
            r_s1_zero  <= i_cmd.out_of_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= take_pixel;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_x     <= r_s1_x;
            r_out_y     <= r_s1_y;
            r_out_word  <= r_s1_zero ? '0 : swap_bytes(r_rd_data);
            r_out_start <= r_s1_start;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_screen_x   = r_out_x;
    assign o_screen_y   = r_out_y;
    assign o_pixel_word = r_out_word;
    assign o_run_start  = r_out_start;

endmodule

>>> src/indexed_line_blitter.sv
// Indexed line blitter: palette writes, line headers and indexed pixels come in
// on one channel; visible pixels leave as byte-swapped RGB565 words with screen
// coordinates and a run-start flag. The block sustains one input beat per clock
// while the command queue has room. Each beat is classified by the front part in
// the cycle it is accepted and, if it produces work, enters a four-entry command
// queue; the back part drains one command a cycle through the single-port
// palette memory while the output is not stalled. A pixel result passes the
// queue write, the registered palette read and the output register before it is
// offered; palette writes produce no output. The palette has no reset: reading an
// entry that was never written gives garbage.
// Configuration writes are taken in any cycle (ready is always high) and must
// only be issued while the block is idle.
module indexed_line_blitter #(
    parameter int BURST_MAX       = ilb_pkg::DEF_BURST_MAX,
    parameter int PALETTE_ENTRIES = ilb_pkg::DEF_PALETTE_ENTRIES,
    parameter int COORD_BITS      = ilb_pkg::DEF_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ilb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ilb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_operation,
    input  logic [ilb_pkg::INDEX_W-1:0]     i_index,
    input  logic [ilb_pkg::COLOR_W-1:0]     i_palette_color,
    input  logic [ilb_pkg::COORD_W-1:0]     i_line_x,
    input  logic [ilb_pkg::COORD_W-1:0]     i_line_y,
    input  logic [ilb_pkg::EXTENT_W-1:0]    i_line_width,
    input  logic [ilb_pkg::INDEX_W-1:0]     i_transparent_index,
    input  logic [ilb_pkg::INDEX_W-1:0]     i_background_index,
    input  logic [2:0]                      i_disposal_mode,
    input  logic                            i_has_transparency,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ilb_pkg::COORD_W-1:0]     o_screen_x,
    output logic [ilb_pkg::COORD_W-1:0]     o_screen_y,
    output logic [ilb_pkg::COLOR_W-1:0]     o_pixel_word,
    output logic                            o_run_start
);
    import ilb_pkg::*;

    logic q_full, q_valid, q_push, q_pop, in_beat;
    t_cmd push_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign in_beat     = i_in_valid && o_in_ready;

    // classification front
    ilb_front #(
        .BURST_MAX       (BURST_MAX),
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .COORD_BITS      (COORD_BITS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_accept            (in_beat),
        .i_operation         (i_operation),
        .i_index             (i_index),
        .i_palette_color     (i_palette_color),
        .i_line_x            (i_line_x),
        .i_line_y            (i_line_y),
        .i_line_width        (i_line_width),
        .i_transparent_index (i_transparent_index),
        .i_background_index  (i_background_index),
        .i_disposal_mode     (i_disposal_mode),
        .i_has_transparency  (i_has_transparency),
        .o_push              (q_push),
        .o_cmd               (push_cmd)
    );

    // command queue
    ilb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_cmd)
    );

    // palette lookup back
    ilb_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_pixel_word (o_pixel_word),
        .o_run_start  (o_run_start)
    );

endmodule

>>> src/ilb_checker.sv
// port-level checker for the indexed line blitter, bound to the top level
// depends on ilb_pkg and indexed_line_blitter_macros.svh
`include "indexed_line_blitter_macros.svh"

module ilb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [ilb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [ilb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic [1:0]                      i_operation,
    input logic [ilb_pkg::INDEX_W-1:0]     i_index,
    input logic [ilb_pkg::COLOR_W-1:0]     i_palette_color,
    input logic [ilb_pkg::COORD_W-1:0]     i_line_x,
    input logic [ilb_pkg::COORD_W-1:0]     i_line_y,
    input logic [ilb_pkg::EXTENT_W-1:0]    i_line_width,
    input logic [ilb_pkg::INDEX_W-1:0]     i_transparent_index,
    input logic [ilb_pkg::INDEX_W-1:0]     i_background_index,
    input logic [2:0]                      i_disposal_mode,
    input logic                            i_has_transparency,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [ilb_pkg::COORD_W-1:0]     o_screen_x,
    input logic [ilb_pkg::COORD_W-1:0]     o_screen_y,
    input logic [ilb_pkg::COLOR_W-1:0]     o_pixel_word,
    input logic                            o_run_start
);
    import ilb_pkg::*;

    logic               out_beat;
    logic               r_have_prev;
    logic [COORD_W-1:0] r_prev_x, r_prev_y;

    assign out_beat = o_out_valid && i_out_ready;

    // remember the last delivered pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (out_beat) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat) begin
            r_prev_x <= o_screen_x;
            r_prev_y <= o_screen_y;
        end
    end

    // output register is empty right after reset
    `ILB_ASSERT_NEXT(a_reset_clears_output, i_clk, !i_rst_n, !o_out_valid)

    // a stalled result holds its payload
    `ILB_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n && o_out_valid && !i_out_ready, !i_rst_n || (o_out_valid && $stable(o_screen_x) && $stable(o_screen_y) && $stable(o_pixel_word) && $stable(o_run_start)))

    // a pixel that continues a burst sits right after the previous one
    `ILB_ASSERT_IMPL(a_burst_continues, i_clk, i_rst_n, out_beat && !o_run_start && r_have_prev, o_screen_x == COORD_W'(r_prev_x + 1'b1) && o_screen_y == r_prev_y)

    // the first pixel after reset opens a burst
    `ILB_ASSERT_IMPL(a_first_opens_burst, i_clk, i_rst_n, out_beat && !r_have_prev, o_run_start)

endmodule

bind indexed_line_blitter ilb_checker u_checker (.*);
